>>> rtl/core/fiti_pkg.sv
// ---------------------------------------------------------------------------
// fiti_pkg
// Shared types, constants and helpers for the file identity table insert block.
// ---------------------------------------------------------------------------
package fiti_pkg;

    localparam int TABLE_DEPTH_LOG2 = 10;
    localparam int SLOT_COUNT       = 1 << TABLE_DEPTH_LOG2;
    localparam int MIN_LOG2         = 4;
    localparam int CFG_W            = 4;
    localparam int CFG_RESET        = 10;
    localparam int LOG2_W           = $clog2(TABLE_DEPTH_LOG2 + 1);
    localparam int KEY_W            = 64;
    localparam int ID_W             = 32;
    localparam int SLOT_W           = 10;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;

    localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int MIX_SHIFT_0 = 30;
    localparam int MIX_SHIFT_1 = 27;
    localparam int MIX_SHIFT_2 = 31;

    // register indexes
    localparam logic [0:0] REG_TABLE_SIZE_LOG2 = 1'b0;

    typedef enum logic [2:0] {
        OUT_INSERTED = 3'd0,
        OUT_SAME     = 3'd1,
        OUT_CONFLICT = 3'd2,
        OUT_FULL     = 3'd3,
        OUT_INVALID  = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MIX,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK
    } back_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]            key;
        logic [ID_W-1:0]             id;
        logic [TABLE_DEPTH_LOG2-1:0] hash;
        logic                        invalid;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // clamp the size register into the supported range
    function automatic logic [LOG2_W-1:0] eff_log2(logic [CFG_W-1:0] v);
        logic [LOG2_W-1:0] r;
        if (int'(v) < MIN_LOG2)
            r = LOG2_W'(MIN_LOG2);
        else if (int'(v) > TABLE_DEPTH_LOG2)
            r = LOG2_W'(TABLE_DEPTH_LOG2);
        else
            r = LOG2_W'(v);
        return r;
    endfunction

endpackage

>>> rtl/core/fiti_front.sv
// ---------------------------------------------------------------------------
// fiti_front
// Accepts insert beats, screens zero key / zero id and computes the
// splitmix64 finalizer with one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
module fiti_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hold,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fiti_pkg::KEY_W-1:0]    file_key,
    input  logic [fiti_pkg::ID_W-1:0]     source_number,
    input  fiti_pkg::q_status_t           q_status,
    output logic                          q_push,
    output fiti_pkg::q_entry_t            q_wdata
);

    fiti_pkg::front_state_t state_reg, state_next;

    logic [fiti_pkg::KEY_W-1:0] x_reg;
    logic [fiti_pkg::KEY_W-1:0] acc_reg;
    logic [fiti_pkg::KEY_W-1:0] key_reg;
    logic [fiti_pkg::ID_W-1:0]  id_reg;
    logic                       invalid_reg;
    logic [1:0]                 step_reg;
    logic                       phase_reg;

    logic                       accept;
    logic                       in_invalid;
    logic [fiti_pkg::KEY_W-1:0] mul_const;
    logic [31:0]                op_a;
    logic [31:0]                op_b;
    logic [63:0]                prod;

    assign accept     = in_valid && !in_stall;
    assign in_invalid = (file_key == '0) || (source_number == '0);

    // 64x64 low half as three 32x32 partial products, one per cycle
    assign mul_const = phase_reg ? fiti_pkg::MIX_MUL_B : fiti_pkg::MIX_MUL_A;
    assign op_a      = (step_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign op_b      = (step_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = op_a * op_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fiti_pkg::F_IDLE:
            begin
                if (accept)
                    state_next = in_invalid ? fiti_pkg::F_PUSH : fiti_pkg::F_MUL;
            end
            fiti_pkg::F_MUL:
            begin
                if (step_reg == 2'd2)
                    state_next = fiti_pkg::F_MIX;
            end
            fiti_pkg::F_MIX:
            begin
                state_next = phase_reg ? fiti_pkg::F_PUSH : fiti_pkg::F_MUL;
            end
            fiti_pkg::F_PUSH:
            begin
                if (!q_status.full)
                    state_next = fiti_pkg::F_IDLE;
            end
            default:
            begin
                state_next = fiti_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        q_push   = 1'b0;
        unique case (state_reg)
            fiti_pkg::F_IDLE:
            begin
                in_stall = hold;
            end
            fiti_pkg::F_PUSH:
            begin
                q_push = !q_status.full;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign q_wdata.key     = key_reg;
    assign q_wdata.id      = id_reg;
    assign q_wdata.hash    = x_reg[fiti_pkg::TABLE_DEPTH_LOG2-1:0];
    assign q_wdata.invalid = invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fiti_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= file_key;
            id_reg      <= source_number;
            invalid_reg <= in_invalid;
            x_reg       <= file_key ^ (file_key >> fiti_pkg::MIX_SHIFT_0);
            step_reg    <= 2'd0;
            phase_reg   <= 1'b0;
        end
        else if (state_reg == fiti_pkg::F_MUL)
        begin
            if (step_reg == 2'd0)
                acc_reg <= prod;
            else
                acc_reg <= acc_reg + {prod[31:0], 32'd0};
            step_reg <= step_reg + 2'd1;
        end
        else if (state_reg == fiti_pkg::F_MIX)
        begin
            if (phase_reg)
                x_reg <= acc_reg ^ (acc_reg >> fiti_pkg::MIX_SHIFT_2);
            else
                x_reg <= acc_reg ^ (acc_reg >> fiti_pkg::MIX_SHIFT_1);
            phase_reg <= 1'b1;
            step_reg  <= 2'd0;
        end
    end

`ifndef SYNTH
    a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("front pushed into a full queue");
    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != fiti_pkg::F_IDLE) |-> in_stall)
        else $error("front open for a beat while hashing");
    a_mul_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fiti_pkg::F_MUL) |-> (step_reg != 2'd3))
        else $error("multiply step out of range");
`endif

endmodule

>>> rtl/core/fiti_queue.sv
// ---------------------------------------------------------------------------
// fiti_queue
// Small fifo that decouples hashing from probing.
// ---------------------------------------------------------------------------
module fiti_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fiti_pkg::q_entry_t  wdata,
    input  logic                pop,
    output fiti_pkg::q_entry_t  rdata,
    output fiti_pkg::q_status_t status
);

    fiti_pkg::q_entry_t entry_reg [fiti_pkg::QUEUE_DEPTH];

    logic [fiti_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fiti_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fiti_pkg::QCNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == fiti_pkg::QCNT_W'(fiti_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (int'(wr_ptr_reg) == fiti_pkg::QUEUE_DEPTH - 1) ?
                              '0 : wr_ptr_reg + fiti_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (int'(rd_ptr_reg) == fiti_pkg::QUEUE_DEPTH - 1) ?
                              '0 : rd_ptr_reg + fiti_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + fiti_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - fiti_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> rtl/core/fiti_back.sv
// ---------------------------------------------------------------------------
// fiti_back
// Owns the key and id stores: clears the key store after reset, then probes
// linearly from the hashed slot and registers one result per request.
// ---------------------------------------------------------------------------
module fiti_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fiti_pkg::CFG_W-1:0]    table_size_log2,
    input  fiti_pkg::q_status_t           q_status,
    input  fiti_pkg::q_entry_t            q_rdata,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [2:0]                    outcome,
    output logic [fiti_pkg::SLOT_W-1:0]   slot_index
);

    localparam int DL = fiti_pkg::TABLE_DEPTH_LOG2;

    fiti_pkg::back_state_t state_reg, state_next;

    logic [fiti_pkg::KEY_W-1:0] key_mem [fiti_pkg::SLOT_COUNT];
    logic [fiti_pkg::ID_W-1:0]  id_mem  [fiti_pkg::SLOT_COUNT];

    logic [fiti_pkg::KEY_W-1:0] key_rd_reg;
    logic [fiti_pkg::ID_W-1:0]  id_rd_reg;
    logic [fiti_pkg::KEY_W-1:0] cur_key_reg;
    logic [fiti_pkg::ID_W-1:0]  cur_id_reg;
    logic [DL-1:0]              pos_reg;
    logic [DL-1:0]              probe_cnt_reg;
    logic [DL-1:0]              clr_cnt_reg;

    logic                       out_valid_reg;
    logic                       accepted_reg;
    fiti_pkg::outcome_t         outcome_reg;
    logic [fiti_pkg::SLOT_W-1:0] slot_reg;

    logic [fiti_pkg::LOG2_W-1:0] eff;
    logic [DL-1:0]              mask;
    logic                       slot_empty;
    logic                       slot_match;
    logic                       last_probe;
    logic [DL-1:0]              mem_addr;
    logic                       key_we;
    logic                       id_we;
    logic [fiti_pkg::KEY_W-1:0] key_wdata;
    logic                       load_out;
    logic                       res_accepted;
    fiti_pkg::outcome_t         res_outcome;
    logic [fiti_pkg::SLOT_W-1:0] res_slot;
    logic                       start;
    logic                       advance;

    assign eff        = fiti_pkg::eff_log2(table_size_log2);
    assign mask       = ~({DL{1'b1}} << eff);
    assign slot_empty = (key_rd_reg == '0);
    assign slot_match = (key_rd_reg == cur_key_reg);
    assign last_probe = (probe_cnt_reg == mask);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fiti_pkg::B_CLEAR:
            begin
                if (&clr_cnt_reg)
                    state_next = fiti_pkg::B_IDLE;
            end
            fiti_pkg::B_IDLE:
            begin
                if (q_pop && !q_rdata.invalid)
                    state_next = fiti_pkg::B_READ;
            end
            fiti_pkg::B_READ:
            begin
                state_next = fiti_pkg::B_CHECK;
            end
            fiti_pkg::B_CHECK:
            begin
                if (slot_empty || slot_match || last_probe)
                    state_next = fiti_pkg::B_IDLE;
                else
                    state_next = fiti_pkg::B_READ;
            end
            default:
            begin
                state_next = fiti_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop        = 1'b0;
        clearing     = 1'b0;
        mem_addr     = pos_reg;
        key_we       = 1'b0;
        id_we        = 1'b0;
        key_wdata    = cur_key_reg;
        load_out     = 1'b0;
        res_accepted = 1'b0;
        res_outcome  = fiti_pkg::OUT_INVALID;
        res_slot     = '0;
        start        = 1'b0;
        advance      = 1'b0;
        unique case (state_reg)
            fiti_pkg::B_CLEAR:
            begin
                clearing  = 1'b1;
                mem_addr  = clr_cnt_reg;
                key_we    = 1'b1;
                key_wdata = '0;
            end
            fiti_pkg::B_IDLE:
            begin
                q_pop = !q_status.empty && !out_valid_reg;
                if (q_pop)
                begin
                    if (q_rdata.invalid)
                        load_out = 1'b1;
                    else
                        start = 1'b1;
                end
            end
            fiti_pkg::B_READ:
            begin
                mem_addr = pos_reg;
            end
            fiti_pkg::B_CHECK:
            begin
                res_slot = fiti_pkg::SLOT_W'(pos_reg);
                if (slot_empty)
                begin
                    key_we       = 1'b1;
                    id_we        = 1'b1;
                    load_out     = 1'b1;
                    res_accepted = 1'b1;
                    res_outcome  = fiti_pkg::OUT_INSERTED;
                end
                else if (slot_match)
                begin
                    load_out     = 1'b1;
                    res_accepted = (id_rd_reg == cur_id_reg);
                    res_outcome  = (id_rd_reg == cur_id_reg) ?
                                   fiti_pkg::OUT_SAME : fiti_pkg::OUT_CONFLICT;
                end
                else if (last_probe)
                begin
                    load_out    = 1'b1;
                    res_outcome = fiti_pkg::OUT_FULL;
                    res_slot    = '0;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fiti_pkg::B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fiti_pkg::B_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + DL'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_key_reg   <= q_rdata.key;
            cur_id_reg    <= q_rdata.id;
            pos_reg       <= q_rdata.hash & mask;
            probe_cnt_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg       <= (pos_reg + DL'(1)) & mask;
            probe_cnt_reg <= probe_cnt_reg + DL'(1);
        end
        if (load_out)
        begin
            accepted_reg <= res_accepted;
            outcome_reg  <= res_outcome;
            slot_reg     <= res_slot;
        end
    end

    // single-port stores, registered read
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[mem_addr] <= key_wdata;
        key_rd_reg <= key_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
            id_mem[mem_addr] <= cur_id_reg;
        id_rd_reg <= id_mem[mem_addr];
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign outcome    = outcome_reg;
    assign slot_index = slot_reg;

`ifndef SYNTH
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg)
        else $error("result register overwritten before delivery");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fiti_pkg::B_CHECK) |-> ((probe_cnt_reg & ~mask) == '0))
        else $error("probe count beyond table size");
    a_pos_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fiti_pkg::B_CHECK) |-> ((pos_reg & ~mask) == '0))
        else $error("probe left the active region");
    a_write_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        (id_we) |-> (slot_empty && state_reg == fiti_pkg::B_CHECK))
        else $error("store written over an occupied slot");
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("request taken during clearing pass");
`endif

endmodule

>>> rtl/core/file_identity_table_insert.sv
// ---------------------------------------------------------------------------
// file_identity_table_insert
// Open-addressing insert of (file key, source id) pairs with linear probing.
// ---------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry key store to zero, one entry a
// cycle, and holds in_stall high during the sweep; configuration writes are
// taken during the sweep. The front end then handles each request in order:
// acceptance, six partial products of the splitmix64 hash on one shared
// 32x32 multiplier, two mix steps and the push into the queue, which waits
// while the queue is full. For each valid request the probe engine pops it,
// then does one registered store read and one compare per slot probed, and
// then waits until the result register has been handed over. A two-beat
// queue lets the front hash the next request while the probe engine works;
// long probe chains make the probe engine the limit.
// Zero key or zero id skips the hash and the store and returns the invalid
// outcome.
// ---------------------------------------------------------------------------
module file_identity_table_insert
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fiti_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fiti_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fiti_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fiti_pkg::KEY_W-1:0]          file_key,
    input  logic [fiti_pkg::ID_W-1:0]           source_number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accepted,
    output logic [2:0]                          outcome,
    output logic [fiti_pkg::SLOT_W-1:0]         slot_index
);

    logic [fiti_pkg::CFG_W-1:0] table_size_log2_reg;
    logic                       cfg_write;
    logic                       clearing;
    logic                       q_push;
    logic                       q_pop;
    fiti_pkg::q_entry_t         q_wdata;
    fiti_pkg::q_entry_t         q_rdata;
    fiti_pkg::q_status_t        q_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == fiti_pkg::REG_TABLE_SIZE_LOG2);
    assign prdata    = (paddr[2] == fiti_pkg::REG_TABLE_SIZE_LOG2) ?
                       fiti_pkg::APB_DATA_W'(table_size_log2_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_log2_reg <= fiti_pkg::CFG_W'(fiti_pkg::CFG_RESET);
        else if (cfg_write)
            table_size_log2_reg <= pwdata[fiti_pkg::CFG_W-1:0];
    end

    fiti_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .hold          (clearing),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .file_key      (file_key),
        .source_number (source_number),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    fiti_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    fiti_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .table_size_log2 (table_size_log2_reg),
        .q_status        (q_status),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .outcome         (outcome),
        .slot_index      (slot_index)
    );

endmodule
